### rtl/icf_pkg.sv
// ----------------------------------------------------------------------------
// icf_pkg: shared types and constants for the constant folding stream
// opcodes, table sizes, controller to datapath command and status structs
// ----------------------------------------------------------------------------
package icf_pkg;

  localparam int VALUE_SLOTS = 1024;
  localparam int LOCAL_SLOTS = 64;
  localparam int SLOT_W = $clog2(VALUE_SLOTS);
  localparam int LOCAL_W = $clog2(LOCAL_SLOTS);

  // epoch mark kept beside each slot tag, bumped by every start
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  localparam logic [4:0] OP_CONST = 5'd0;
  localparam logic [4:0] OP_COPY = 5'd1;
  localparam logic [4:0] OP_STLOCAL = 5'd2;
  localparam logic [4:0] OP_LDLOCAL = 5'd3;
  localparam logic [4:0] OP_ADDRLOCAL = 5'd4;
  localparam logic [4:0] OP_MEMSTORE = 5'd5;
  localparam logic [4:0] OP_BRIF = 5'd6;
  localparam logic [4:0] OP_BR = 5'd7;
  localparam logic [4:0] OP_LABEL = 5'd8;
  localparam logic [4:0] OP_CALL = 5'd9;
  localparam logic [4:0] OP_ADD = 5'd10;
  localparam logic [4:0] OP_SUB = 5'd11;
  localparam logic [4:0] OP_MUL = 5'd12;
  localparam logic [4:0] OP_DIV = 5'd13;
  localparam logic [4:0] OP_MOD = 5'd14;
  localparam logic [4:0] OP_AND = 5'd15;
  localparam logic [4:0] OP_OR = 5'd16;
  localparam logic [4:0] OP_XOR = 5'd17;
  localparam logic [4:0] OP_SHL = 5'd18;
  localparam logic [4:0] OP_SAR = 5'd19;
  localparam logic [4:0] OP_CMP = 5'd20;
  localparam logic [4:0] OP_NOP = 5'd21;

  localparam logic [2:0] CK_EQ = 3'd0;
  localparam logic [2:0] CK_NE = 3'd1;
  localparam logic [2:0] CK_LT = 3'd2;
  localparam logic [2:0] CK_LE = 3'd3;
  localparam logic [2:0] CK_GT = 3'd4;
  localparam logic [2:0] CK_GE = 3'd5;

  localparam logic [10:0] SLOT_NONE = 11'h7FF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item, launch table reads
    logic decide;    // operands valid, evaluate instruction
    logic div_go;    // start divider
    logic mul_lo;    // first mul partial product step
    logic mul_hi;    // second mul step
    logic finish;    // commit result and table writes
    logic clr;       // clear one slot tag
  } icf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic need_mul;
    logic div_done;
    logic need_clr;  // start would wrap the epoch
    logic clr_last;  // clearing pass at its last tag
  } icf_sts_t;

endpackage

### rtl/ir_constant_folding_stream.sv
// ----------------------------------------------------------------------------
// ir_constant_folding_stream: streaming constant propagation and folding
// tracks known constants in value slots and locals, rewrites instructions
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_ready  | start_req func dst src_a src_b imm cmp_kind
//  output  | out       | out_valid/out_ready| rewritten new_func new_a new_b new_imm
//
// an instruction goes through a table read, then decide and commit
// a folded mul adds two 32x32 partial product steps
// a folded div or mod runs through the bit-serial divider
// after rst a pass clears all 1024 slot tags before the first transfer
// a start that would wrap the 8-bit epoch reruns that pass first
// a stalled output holds the finished result; the next instruction is accepted but its commit waits for it
module ir_constant_folding_stream import icf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               start_req,
  input  logic [4:0]         func,
  input  logic signed [10:0] dst,
  input  logic signed [10:0] src_a,
  input  logic signed [10:0] src_b,
  input  logic signed [63:0] imm,
  input  logic [2:0]         cmp_kind,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               rewritten,
  output logic [4:0]         new_func,
  output logic signed [10:0] new_a,
  output logic signed [10:0] new_b,
  output logic signed [63:0] new_imm
);

  icf_cmd_t cmd;
  icf_sts_t sts;

  // sequencing
  icf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // tables and arithmetic
  icf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .start_req (start_req),
    .func      (func),
    .dst       (dst),
    .src_a     (src_a),
    .src_b     (src_b),
    .imm       (imm),
    .cmp_kind  (cmp_kind),
    .rewritten (rewritten),
    .new_func  (new_func),
    .new_a     (new_a),
    .new_b     (new_b),
    .new_imm   (new_imm)
  );

endmodule

### rtl/icf_div.sv
// ----------------------------------------------------------------------------
// icf_div: signed 64-bit divider
// radix-2 restoring, one quotient bit per cycle, truncating quotient/remainder
// ----------------------------------------------------------------------------
module icf_div import icf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quo,
  output logic [63:0] rem
);

  logic        busy;
  logic [6:0]  count;
  logic [63:0] q;
  logic [63:0] r;
  logic [63:0] d;
  logic        neg_q;
  logic        neg_r;
  logic [64:0] trial;
  logic [63:0] r_shift;

  assign r_shift = {r[62:0], q[63]};
  assign trial = {1'b0, r_shift} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        count <= 7'd64;
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q <= num[63] ? (~num + 64'd1) : num;
      d <= den[63] ? (~den + 64'd1) : den;
      r <= '0;
      neg_q <= num[63] ^ den[63];
      neg_r <= num[63];
    end else if (busy) begin
      if (!trial[64]) begin
        r <= trial[63:0];
        q <= {q[62:0], 1'b1};
      end else begin
        r <= r_shift;
        q <= {q[62:0], 1'b0};
      end
    end
  end

  assign quo = neg_q ? (~q + 64'd1) : q;
  assign rem = neg_r ? (~r + 64'd1) : r;

endmodule

### rtl/icf_ctrl.sv
// ----------------------------------------------------------------------------
// icf_ctrl: sequencing of one instruction
// tag clearing pass, read, decide, optional multiply or divide steps
// ----------------------------------------------------------------------------
module icf_ctrl import icf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output icf_cmd_t cmd,
  input  icf_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_INIT = 3'd5;
  localparam logic [2:0] S_CLR = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  // output register frees when empty or taken this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_INIT: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (sts.need_clr) begin
          state_next = S_CLR;
        end else begin
          cmd.decide = 1'b1;
          if (sts.need_div) begin
            cmd.div_go = 1'b1;
            state_next = S_DIV;
          end else if (sts.need_mul) begin
            cmd.mul_lo = 1'b1;
            state_next = S_MUL1;
          end else if (out_free) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_READ;
      end
      S_MUL1: begin
        cmd.mul_hi = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_next = S_MUL2;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("ready outside idle");
  a_load_goes_read: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_READ)
    else $error("load did not enter read");
  a_finish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finish lost result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.finish)
    else $error("result overwritten");

endmodule

### rtl/icf_dp.sv
// ----------------------------------------------------------------------------
// icf_dp: tables and folding datapath
// slot value and tag memories, local tables, alu, result register
// ----------------------------------------------------------------------------
module icf_dp import icf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  icf_cmd_t           cmd,
  output icf_sts_t           sts,
  input  logic               start_req,
  input  logic [4:0]         func,
  input  logic signed [10:0] dst,
  input  logic signed [10:0] src_a,
  input  logic signed [10:0] src_b,
  input  logic signed [63:0] imm,
  input  logic [2:0]         cmp_kind,
  output logic               rewritten,
  output logic [4:0]         new_func,
  output logic signed [10:0] new_a,
  output logic signed [10:0] new_b,
  output logic signed [63:0] new_imm
);

  // captured instruction
  logic        r_start;
  logic [4:0]  r_func;
  logic [10:0] r_dst;
  logic [10:0] r_a;
  logic [10:0] r_b;
  logic [63:0] r_imm;
  logic [2:0]  r_ck;

  // tables
  logic [63:0]            slot_mem_a [VALUE_SLOTS];
  logic [63:0]            slot_mem_b [VALUE_SLOTS];
  logic [EPOCH_W:0]       slot_tag_a [VALUE_SLOTS];  // {known, epoch}
  logic [EPOCH_W:0]       slot_tag_b [VALUE_SLOTS];
  logic [63:0]            lvar_value [LOCAL_SLOTS];
  logic [LOCAL_SLOTS-1:0] lvar_known;
  logic [LOCAL_SLOTS-1:0] local_taken;
  logic [63:0]            va;
  logic [63:0]            vb;
  logic [63:0]            vl;
  logic [EPOCH_W:0]       ta;
  logic [EPOCH_W:0]       tb;
  logic [EPOCH_W-1:0]     epoch;
  logic [EPOCH_W-1:0]     epoch_next;
  logic [SLOT_W-1:0]      clr_idx;

  logic a_ok;
  logic b_ok;
  logic d_ok;
  logic lok;
  logic [SLOT_W-1:0]  ai;
  logic [SLOT_W-1:0]  bi;
  logic [SLOT_W-1:0]  di;
  logic [LOCAL_W-1:0] li;
  logic ak;
  logic bk;
  logic lk;

  // decision results, held through multi-cycle ops
  logic        d_rw;
  logic [4:0]  d_nf;
  logic [10:0] d_na;
  logic [10:0] d_nb;
  logic [63:0] d_ni;
  logic        d_wr;
  logic        d_wk;
  logic        d_lwr;
  logic        d_lk;
  logic        d_taken;
  logic        d_clr;
  logic        d_mst;
  logic        d_fold;
  logic        h_rw, h_wr, h_wk, h_lwr, h_lk, h_taken, h_clr, h_mst;
  logic        h_mul, h_div, h_mod;
  logic [4:0]  h_nf;
  logic [10:0] h_na, h_nb;
  logic [63:0] h_ni;
  logic [63:0] f_r;
  logic        f_ok;
  logic        is_mul;
  logic        is_div;
  logic        div_bad;

  // values committed at finish: fresh decision or the held one
  logic        c_rw, c_wr, c_wk, c_lwr, c_lk, c_taken, c_clr, c_mst;
  logic [4:0]  c_nf;
  logic [10:0] c_na, c_nb;
  logic [63:0] c_ni;

  // multiplier partial products (32x32 per step)
  logic [63:0] mp_ll;
  logic [63:0] mp_cross;
  logic [31:0] mp_a_hi;
  logic [63:0] mul_res;
  logic [63:0] q;
  logic [63:0] rm;
  logic        div_done;
  logic [63:0] res_ni;

  logic signed [63:0] sa;
  logic signed [63:0] sb;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_start <= start_req;
      r_func <= func;
      r_dst <= dst;
      r_a <= src_a;
      r_b <= src_b;
      r_imm <= imm;
      r_ck <= cmp_kind;
    end
  end

  assign ai = src_a[SLOT_W-1:0];
  assign bi = src_b[SLOT_W-1:0];

  // synchronous reads at load, two copies serve both operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va <= slot_mem_a[ai];
      vb <= slot_mem_b[bi];
      ta <= slot_tag_a[ai];
      tb <= slot_tag_b[bi];
      vl <= lvar_value[imm[LOCAL_W-1:0]];
    end
  end

  assign a_ok = !r_a[10] && (r_a < 11'(VALUE_SLOTS));
  assign b_ok = !r_b[10] && (r_b < 11'(VALUE_SLOTS));
  assign d_ok = !r_dst[10] && (r_dst < 11'(VALUE_SLOTS));
  assign di = r_dst[SLOT_W-1:0];
  assign lok = (r_imm < 64'(LOCAL_SLOTS));
  assign li = r_imm[LOCAL_W-1:0];
  // a slot is known only when tagged in the current epoch
  assign ak = a_ok && !r_start && ta[EPOCH_W] && (ta[EPOCH_W-1:0] == epoch);
  assign bk = b_ok && !r_start && tb[EPOCH_W] && (tb[EPOCH_W-1:0] == epoch);
  assign lk = !r_start && lvar_known[li];
  assign epoch_next = r_start ? (epoch + EPOCH_W'(1)) : epoch;

  assign sa = va;
  assign sb = vb;
  assign is_mul = (r_func == OP_MUL);
  assign is_div = (r_func == OP_DIV) || (r_func == OP_MOD);
  assign div_bad = (vb == 64'd0) || (va == SMIN && vb == '1);

  // combinational fold results; mul and div/mod only report whether they can fold
  always_comb begin
    f_ok = 1'b1;
    f_r = '0;
    case (r_func)
      OP_ADD: f_r = va + vb;
      OP_SUB: f_r = va - vb;
      OP_MUL: f_r = '0;
      OP_DIV, OP_MOD: f_ok = !div_bad;
      OP_AND: f_r = va & vb;
      OP_OR: f_r = va | vb;
      OP_XOR: f_r = va ^ vb;
      OP_SHL: begin
        f_ok = (vb[63:6] == '0);
        f_r = va << vb[5:0];
      end
      OP_SAR: begin
        f_ok = (vb[63:6] == '0);
        f_r = sa >>> vb[5:0];
      end
      OP_CMP: begin
        case (r_ck)
          CK_EQ: f_r = 64'(sa == sb);
          CK_NE: f_r = 64'(sa != sb);
          CK_LT: f_r = 64'(sa < sb);
          CK_LE: f_r = 64'(sa <= sb);
          CK_GT: f_r = 64'(sa > sb);
          CK_GE: f_r = 64'(sa >= sb);
          default: f_ok = 1'b0;
        endcase
      end
      default: f_ok = 1'b0;
    endcase
  end

  // instruction decision
  always_comb begin
    logic [4:0] op;
    logic       ak2;
    op = r_func;
    d_rw = 1'b0;
    d_nf = r_func;
    d_na = r_a;
    d_nb = r_b;
    d_ni = r_imm;
    d_wr = 1'b0;
    d_wk = 1'b0;
    d_lwr = 1'b0;
    d_lk = 1'b0;
    d_taken = 1'b0;
    d_clr = 1'b0;
    d_mst = 1'b0;
    d_fold = 1'b0;
    ak2 = ak;
    if (r_func == OP_CONST && !r_dst[10]) begin
      d_wr = 1'b1;
      d_wk = 1'b1;
    end else if (r_func == OP_COPY && !r_dst[10]) begin
      d_wr = 1'b1;
      d_wk = ak;
      if (ak) begin
        d_rw = 1'b1;
        d_nf = OP_CONST;
        d_ni = va;
        d_na = SLOT_NONE;
        d_nb = SLOT_NONE;
      end
    end else if (r_func == OP_STLOCAL && lok) begin
      d_lwr = 1'b1;
      d_lk = ak;
    end else if (r_func == OP_LDLOCAL && !r_dst[10] && lok && lk) begin
      d_rw = 1'b1;
      d_nf = OP_CONST;
      d_ni = vl;
      d_na = SLOT_NONE;
      d_nb = SLOT_NONE;
      d_wr = 1'b1;
      d_wk = 1'b1;
    end else if (r_func == OP_ADDRLOCAL && lok) begin
      d_taken = 1'b1;
      d_wr = 1'b1;
    end else begin
      d_mst = (r_func == OP_MEMSTORE);
      if (r_func == OP_BRIF && ak) begin
        d_rw = 1'b1;
        d_na = SLOT_NONE;
        d_nb = SLOT_NONE;
        ak2 = 1'b0;
        if (va != '0) begin
          op = OP_BR;
        end else begin
          op = OP_NOP;
          d_ni = '0;
        end
        d_nf = op;
      end
      d_clr = (op == OP_LABEL) || (op == OP_BR) || (op == OP_BRIF) || (op == OP_CALL);
      d_wr = 1'b1;
      if (!r_dst[10] && ak2 && bk && f_ok) begin
        d_fold = 1'b1;
        d_wk = 1'b1;
        d_rw = 1'b1;
        d_nf = OP_CONST;
        d_ni = f_r;
        d_na = SLOT_NONE;
        d_nb = SLOT_NONE;
      end
    end
  end

  assign sts.need_mul = d_fold && is_mul;
  assign sts.need_div = d_fold && is_div;
  assign sts.div_done = div_done;
  assign sts.need_clr = r_start && (epoch == EPOCH_LAST);
  assign sts.clr_last = (clr_idx == '1);

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      h_rw <= d_rw;
      h_nf <= d_nf;
      h_na <= d_na;
      h_nb <= d_nb;
      h_ni <= d_ni;
      h_wr <= d_wr;
      h_wk <= d_wk;
      h_lwr <= d_lwr;
      h_lk <= d_lk;
      h_taken <= d_taken;
      h_clr <= d_clr;
      h_mst <= d_mst;
      h_mul <= d_fold && is_mul;
      h_div <= d_fold && (r_func == OP_DIV);
      h_mod <= d_fold && (r_func == OP_MOD);
    end
  end

  // two-step 64-bit wrapping multiply from 32x32 products
  always_ff @(posedge clk) begin
    if (cmd.mul_lo) begin
      mp_ll <= va[31:0] * vb[31:0];
      mp_cross <= {32'd0, va[31:0] * vb[63:32]};
      mp_a_hi <= va[63:32];
    end else if (cmd.mul_hi) begin
      mp_cross <= {32'd0, mp_cross[31:0] + 32'(mp_a_hi * vb[31:0])};
    end
  end
  assign mul_res = mp_ll + {mp_cross[31:0], 32'd0};

  icf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .num  (va),
    .den  (vb),
    .done (div_done),
    .quo  (q),
    .rem  (rm)
  );

  always_comb begin
    res_ni = h_ni;
    if (h_mul) res_ni = mul_res;
    else if (h_div) res_ni = q;
    else if (h_mod) res_ni = rm;
  end

  // finishing straight from decide uses the decision of this cycle
  always_comb begin
    if (cmd.decide) begin
      c_rw = d_rw;
      c_nf = d_nf;
      c_na = d_na;
      c_nb = d_nb;
      c_ni = d_ni;
      c_wr = d_wr;
      c_wk = d_wk;
      c_lwr = d_lwr;
      c_lk = d_lk;
      c_taken = d_taken;
      c_clr = d_clr;
      c_mst = d_mst;
    end else begin
      c_rw = h_rw;
      c_nf = h_nf;
      c_na = h_na;
      c_nb = h_nb;
      c_ni = res_ni;
      c_wr = h_wr;
      c_wk = h_wk;
      c_lwr = h_lwr;
      c_lk = h_lk;
      c_taken = h_taken;
      c_clr = h_clr;
      c_mst = h_mst;
    end
  end

  // commit
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rewritten <= c_rw;
      new_func <= c_nf;
      new_a <= c_na;
      new_b <= c_nb;
      new_imm <= c_ni;
      if (c_wr && d_ok && c_wk) begin
        slot_mem_a[di] <= c_ni;
        slot_mem_b[di] <= c_ni;
      end
      if (c_lwr && c_lk) lvar_value[li] <= va;
    end
  end

  // slot tags: clearing pass one entry a cycle, else destination update
  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      slot_tag_a[clr_idx] <= '0;
      slot_tag_b[clr_idx] <= '0;
    end else if (cmd.finish && c_wr && d_ok) begin
      slot_tag_a[di] <= {c_wk, epoch_next};
      slot_tag_b[di] <= {c_wk, epoch_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch <= '0;
      clr_idx <= '0;
    end else if (cmd.clr) begin
      clr_idx <= clr_idx + SLOT_W'(1);
      if (clr_idx == '1) epoch <= '0;
    end else if (cmd.finish) begin
      epoch <= epoch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvar_known <= '0;
      local_taken <= '0;
    end else if (cmd.finish) begin
      logic [LOCAL_SLOTS-1:0] lkn;
      logic [LOCAL_SLOTS-1:0] lt;
      lkn = r_start ? '0 : lvar_known;
      lt = r_start ? '0 : local_taken;
      if (c_lwr) lkn[li] = c_lk;
      if (c_taken) begin
        lt[li] = 1'b1;
        lkn[li] = 1'b0;
      end
      if (c_mst) lkn = lkn & ~lt;
      if (c_clr) lkn = '0;
      lvar_known <= lkn;
      local_taken <= lt;
    end
  end

endmodule
